@@ hdl/serial_line_editor_core_assert.svh @@
// Assertion macros for the line editor RTL.
`ifndef SERIAL_LINE_EDITOR_CORE_ASSERT_SVH
`define SERIAL_LINE_EDITOR_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SLE_ASSERT_IMPLY(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SLE_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/sle_pkg.sv @@
package sle_pkg;

  // Default line store depth
  localparam int LINE_DEPTH_DEF = 32;

  // Field widths
  localparam int CHAR_W    = 7;
  localparam int IN_W      = 8;
  localparam int LEN_W     = 6;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int TDATA_W   = 24;
  localparam int TUSER_W   = 2;

  // Result tdata bit positions, lowest field first
  localparam int TD_ECHO_VALID = 0;
  localparam int TD_ECHO_LSB   = 1;
  localparam int TD_LINE_VALID = 8;
  localparam int TD_LINE_LSB   = 9;
  localparam int TD_LEN_LSB    = 16;

  // Received byte mask and control characters
  localparam logic [IN_W-1:0]   CHAR_MASK = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_NUL    = 7'd0;
  localparam logic [CHAR_W-1:0] CH_BS     = 7'd8;
  localparam logic [CHAR_W-1:0] CH_LF     = 7'd10;
  localparam logic [CHAR_W-1:0] CH_CR     = 7'd13;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 7'd59;
  localparam logic [CHAR_W-1:0] CH_DEL    = 7'd127;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEMI_ENDS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT  = 2'd2;

  localparam logic [CFG_W-1:0] LIMIT_RESET = 6'd32;

  typedef enum logic [TUSER_W-1:0] {
    STATUS_LINE = 2'd0,
    STATUS_EOL  = 2'd1,
    STATUS_OVF  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  typedef enum logic [1:0] {
    KIND_STEP,
    KIND_LINE,
    KIND_FINAL
  } out_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic      rx_load;
    logic      ram_wr;
    logic      ram_rd;
    cnt_op_t   cnt_op;
    logic      idx_inc;
    logic      out_load;
    out_kind_t out_kind;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_eol;
    logic is_del;
    logic cnt_zero;
    logic full;
    logic drain_done;
    logic out_free;
  } stat_t;

endpackage

@@ hdl/serial_line_editor_core.sv @@
// Serial line editor: edits received characters into lines.
// Input stream s_*: one received byte per transfer in s_tdata[7:0]; bit 7
// is ignored. Output stream m_*: one result per transfer, the status code
// in m_tuser and the final result of each input marked by m_tlast.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 echo
// enable, 1 semicolon ends line, 2 line limit); the user must write only
// while idle, which the block itself does not enforce. The block takes one
// character at a time. After a transfer in, it holds the character in its
// execute state; for an ordinary character, a delete or an overflow it
// presents the result and raises s_tready in the same cycle, once the
// output slot is free. An end of line reads the line store once per held
// character through its single registered read port, a read and a wait state each.
// A result waits in the output register; the block accepts the next
// character meanwhile, and stalls in its sequencer only when it must
// present a new result while the old one has not been taken.
// Synchronous reset empties the line, drops any pending result and
// restores the registers (echo off, semicolon mode off, limit 32).
// The line store needs no clearing pass: only held entries are read.
`include "serial_line_editor_core_assert.svh"

module serial_line_editor_core #(
  parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: rx_char[7:0]
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sle_pkg::IN_W-1:0]      s_tdata,
  // m_tdata: echo_valid[0], echo_char[7:1], line_valid[8], line_char[15:9],
  //          line_length[21:16], zero[23:22]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sle_pkg::TDATA_W-1:0]   m_tdata,
  // m_tuser: status[1:0]
  output logic [sle_pkg::TUSER_W-1:0]   m_tuser,
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [sle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sle_pkg::CFG_W-1:0]     cfg_data
);

  sle_pkg::cmd_t               cmd;
  sle_pkg::stat_t              stat;
  sle_pkg::status_t            out_status;
  logic                        out_echo_valid;
  logic [sle_pkg::CHAR_W-1:0]  out_echo_char;
  logic                        out_line_valid;
  logic [sle_pkg::CHAR_W-1:0]  out_line_char;
  logic [sle_pkg::LEN_W-1:0]   out_line_length;

  sle_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  sle_dp #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .rx_char        (s_tdata),
    .out_ready      (m_tready),
    .out_valid      (m_tvalid),
    .out_status     (out_status),
    .out_echo_valid (out_echo_valid),
    .out_echo_char  (out_echo_char),
    .out_line_valid (out_line_valid),
    .out_line_char  (out_line_char),
    .out_line_length(out_line_length),
    .out_last       (m_tlast),
    .cmd            (cmd),
    .stat           (stat)
  );

  // Pack the result fields
  assign m_tdata = {2'b00, out_line_length, out_line_char, out_line_valid,
                    out_echo_char, out_echo_valid};
  assign m_tuser = out_status;

  `SLE_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready,
    "character accepted while the previous one is in work")
  `SLE_ASSERT_IMPLY(a_write_below_limit, clk, rst, cmd.ram_wr, !stat.full && !stat.is_eol,
    "line store written at or past the limit")
  `SLE_ASSERT_IMPLY(a_no_overwrite, clk, rst, cmd.out_load, stat.out_free,
    "pending result overwritten")
  `SLE_ASSERT_IMPLY(a_line_char_eol, clk, rst,
    m_tvalid && m_tdata[sle_pkg::TD_LINE_VALID],
    (m_tuser == sle_pkg::STATUS_EOL) && !m_tlast,
    "line character outside an end-of-line drain")

endmodule

@@ hdl/sle_ram.sv @@
module sle_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/sle_ctrl.sv @@
module sle_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sle_pkg::stat_t stat,
  output sle_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DRAIN_RD,
    ST_DRAIN_WAIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  // Decode commands and the next state
  always_comb begin
    cmd          = '0;
    cmd.cnt_op   = sle_pkg::CNT_HOLD;
    cmd.out_kind = sle_pkg::KIND_STEP;
    state_next   = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.rx_load = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.out_free) begin
          if (stat.is_eol) begin
            if (stat.cnt_zero) begin
              cmd.out_load = 1'b1;
              cmd.out_kind = sle_pkg::KIND_FINAL;
              cmd.cnt_op   = sle_pkg::CNT_CLR;
              state_next   = ST_IDLE;
            end else begin
              cmd.ram_rd = 1'b1;
              state_next = ST_DRAIN_RD;
            end
          end else if (stat.is_del) begin
            cmd.out_load = 1'b1;
            cmd.cnt_op   = stat.cnt_zero ? sle_pkg::CNT_HOLD : sle_pkg::CNT_DEC;
            state_next   = ST_IDLE;
          end else if (stat.full) begin
            cmd.out_load = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            cmd.ram_wr   = 1'b1;
            cmd.out_load = 1'b1;
            cmd.cnt_op   = sle_pkg::CNT_INC;
            state_next   = ST_IDLE;
          end
        end
      end
      ST_DRAIN_RD: begin
        // read data is ready and the output slot was free when it was issued
        cmd.out_load = 1'b1;
        cmd.out_kind = sle_pkg::KIND_LINE;
        cmd.idx_inc  = 1'b1;
        state_next   = ST_DRAIN_WAIT;
      end
      ST_DRAIN_WAIT: begin
        if (stat.out_free) begin
          if (stat.drain_done) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = sle_pkg::KIND_FINAL;
            cmd.cnt_op   = sle_pkg::CNT_CLR;
            state_next   = ST_IDLE;
          end else begin
            cmd.ram_rd = 1'b1;
            state_next = ST_DRAIN_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hdl/sle_dp.sv @@
module sle_dp #(
  parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sle_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sle_pkg::CFG_W-1:0]       cfg_data,
  input  logic [sle_pkg::IN_W-1:0]        rx_char,
  input  logic                            out_ready,
  output logic                            out_valid,
  output sle_pkg::status_t                out_status,
  output logic                            out_echo_valid,
  output logic [sle_pkg::CHAR_W-1:0]      out_echo_char,
  output logic                            out_line_valid,
  output logic [sle_pkg::CHAR_W-1:0]      out_line_char,
  output logic [sle_pkg::LEN_W-1:0]       out_line_length,
  output logic                            out_last,
  input  sle_pkg::cmd_t                   cmd,
  output sle_pkg::stat_t                  stat
);

  localparam int CNT_W  = $clog2(LINE_DEPTH + 1);
  localparam int ADDR_W = $clog2(LINE_DEPTH);
  localparam logic [sle_pkg::CFG_W-1:0] DEPTH_LIM = sle_pkg::CFG_W'(LINE_DEPTH);

  logic                          echo_enable;
  logic                          semi_ends;
  logic [sle_pkg::CFG_W-1:0]     line_limit;
  logic [sle_pkg::CHAR_W-1:0]    rx_c;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              idx;
  logic [sle_pkg::CHAR_W-1:0]    rd_data;
  logic [sle_pkg::CFG_W-1:0]     limit_eff;
  logic                          is_eol;
  logic                          is_del;
  logic                          cnt_zero;
  logic                          full;
  sle_pkg::status_t              status_next;
  logic                          echo_valid_next;
  logic [sle_pkg::CHAR_W-1:0]    echo_char_next;
  logic                          line_valid_next;
  logic [sle_pkg::CHAR_W-1:0]    line_char_next;
  logic [sle_pkg::LEN_W-1:0]     line_length_next;
  logic                          last_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_enable <= 1'b0;
      semi_ends   <= 1'b0;
      line_limit  <= sle_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sle_pkg::REG_ECHO_ENABLE: echo_enable <= cfg_data[0];
        sle_pkg::REG_SEMI_ENDS:   semi_ends   <= cfg_data[0];
        sle_pkg::REG_LINE_LIMIT:  line_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the received character, top bit dropped
  always_ff @(posedge clk) begin
    if (cmd.rx_load) begin
      rx_c <= sle_pkg::CHAR_W'(rx_char & sle_pkg::CHAR_MASK);
    end
  end

  // Classify the held character
  always_comb begin
    is_eol    = (rx_c == sle_pkg::CH_NUL) || (rx_c == sle_pkg::CH_LF) ||
                (rx_c == sle_pkg::CH_CR) || (semi_ends && (rx_c == sle_pkg::CH_SEMI));
    is_del    = (rx_c == sle_pkg::CH_BS) || (rx_c == sle_pkg::CH_DEL);
    limit_eff = (line_limit > DEPTH_LIM) ? DEPTH_LIM : line_limit;
    cnt_zero  = (count == '0);
    full      = (sle_pkg::CFG_W'(count) >= limit_eff);
  end

  assign stat.is_eol     = is_eol;
  assign stat.is_del     = is_del;
  assign stat.cnt_zero   = cnt_zero;
  assign stat.full       = full;
  assign stat.drain_done = (idx == count);
  assign stat.out_free   = !out_valid || out_ready;

  // Line count and drain index
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.cnt_op)
        sle_pkg::CNT_INC: count <= count + 1'b1;
        sle_pkg::CNT_DEC: count <= count - 1'b1;
        sle_pkg::CNT_CLR: count <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.rx_load) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  sle_ram #(
    .WIDTH(sle_pkg::CHAR_W),
    .DEPTH(LINE_DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (cmd.ram_wr),
    .waddr(count[ADDR_W-1:0]),
    .wdata(rx_c),
    .re   (cmd.ram_rd),
    .raddr(idx[ADDR_W-1:0]),
    .rdata(rd_data)
  );

  // Output valid flag: set on load, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Select the next result payload
  always_comb begin
    echo_valid_next  = 1'b0;
    echo_char_next   = '0;
    line_valid_next  = 1'b0;
    line_char_next   = '0;
    line_length_next = '0;
    last_next        = 1'b1;
    status_next      = sle_pkg::STATUS_LINE;
    case (cmd.out_kind)
      sle_pkg::KIND_LINE: begin
        status_next     = sle_pkg::STATUS_EOL;
        line_valid_next = 1'b1;
        line_char_next  = rd_data;
        last_next       = 1'b0;
      end
      sle_pkg::KIND_FINAL: begin
        status_next     = sle_pkg::STATUS_EOL;
        echo_valid_next = echo_enable;
        echo_char_next  = echo_enable ? sle_pkg::CH_LF : '0;
      end
      default: begin
        if (is_del) begin
          if (!cnt_zero) begin
            echo_valid_next  = echo_enable;
            echo_char_next   = echo_enable ? rx_c : '0;
            line_length_next = sle_pkg::LEN_W'(count - 1'b1);
          end
        end else if (full) begin
          status_next      = sle_pkg::STATUS_OVF;
          line_length_next = sle_pkg::LEN_W'(count);
        end else begin
          echo_valid_next  = echo_enable;
          echo_char_next   = echo_enable ? rx_c : '0;
          line_length_next = sle_pkg::LEN_W'(count + 1'b1);
        end
      end
    endcase
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status      <= status_next;
      out_echo_valid  <= echo_valid_next;
      out_echo_char   <= echo_char_next;
      out_line_valid  <= line_valid_next;
      out_line_char   <= line_char_next;
      out_line_length <= line_length_next;
      out_last        <= last_next;
    end
  end

endmodule

@@ tb/serial_line_editor_checker.sv @@
module serial_line_editor_checker #(
  parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [sle_pkg::IN_W-1:0]      s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [sle_pkg::TDATA_W-1:0]   m_tdata,
  input  logic [sle_pkg::TUSER_W-1:0]   m_tuser,
  input  logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [sle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sle_pkg::CFG_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            pending_cnt,
  output int                            results_seen,
  output int                            lines_seen,
  output int                            drops_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  typedef struct packed {
    status_t           status;
    logic              echo_valid;
    logic [CHAR_W-1:0] echo_char;
    logic              line_valid;
    logic [CHAR_W-1:0] line_char;
    logic [LEN_W-1:0]  line_length;
    logic              last;
  } line_result_t;

  // Results still owed by the block, oldest first
  line_result_t      owed_q[$];

  // Mirror of the editor state and its registers
  logic [CHAR_W-1:0] line_buf [LINE_DEPTH];
  int                line_cnt;
  logic              echo_on;
  logic              semi_on;
  logic [CFG_W-1:0]  limit_reg;

  int errors = 0;
  int n_results = 0;
  int n_lines = 0;
  int n_drops = 0;

  initial begin
    fail_count   = 0;
    pending_cnt  = 0;
    results_seen = 0;
    lines_seen   = 0;
    drops_seen   = 0;
  end

  function automatic line_result_t make_result(input status_t st, input logic ev,
                                               input logic [CHAR_W-1:0] ec, input logic lv,
                                               input logic [CHAR_W-1:0] lc, input int len,
                                               input logic lst);
    line_result_t r;
    r.status      = st;
    r.echo_valid  = ev;
    r.echo_char   = ec;
    r.line_valid  = lv;
    r.line_char   = lc;
    r.line_length = LEN_W'(len);
    r.last        = lst;
    return r;
  endfunction

  // Edit one received character into the line and queue what it yields
  task automatic edit_char(input logic [IN_W-1:0] rx);
    logic [CHAR_W-1:0] c;
    int                lim;
    int                cnt;
    c   = rx[CHAR_W-1:0];
    lim = (limit_reg > LINE_DEPTH) ? LINE_DEPTH : int'(limit_reg);
    cnt = (line_cnt > LINE_DEPTH) ? LINE_DEPTH : line_cnt;
    if (c == CH_NUL || c == CH_LF || c == CH_CR || (c == CH_SEMI && semi_on)) begin
      // drain the held characters, then the closing result
      for (int i = 0; i < cnt; i++)
        owed_q.push_back(make_result(STATUS_EOL, 1'b0, '0, 1'b1, line_buf[i], 0, 1'b0));
      line_cnt = 0;
      owed_q.push_back(make_result(STATUS_EOL, echo_on, echo_on ? CH_LF : '0,
                                   1'b0, '0, 0, 1'b1));
    end else if (c == CH_BS || c == CH_DEL) begin
      if (cnt > 0) begin
        line_cnt = cnt - 1;
        owed_q.push_back(make_result(STATUS_LINE, echo_on, echo_on ? c : '0,
                                     1'b0, '0, line_cnt, 1'b1));
      end else begin
        line_cnt = 0;
        owed_q.push_back(make_result(STATUS_LINE, 1'b0, '0, 1'b0, '0, 0, 1'b1));
      end
    end else if (cnt >= lim) begin
      owed_q.push_back(make_result(STATUS_OVF, 1'b0, '0, 1'b0, '0, cnt, 1'b1));
    end else begin
      line_buf[cnt] = c;
      line_cnt      = cnt + 1;
      owed_q.push_back(make_result(STATUS_LINE, echo_on, echo_on ? c : '0,
                                   1'b0, '0, line_cnt, 1'b1));
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Track register writes, predict on each input transfer, compare each output transfer
  always @(posedge clk) begin : monitor
    line_result_t want;
    if (rst) begin
      owed_q.delete();
      line_cnt  = 0;
      echo_on   = 1'b0;
      semi_on   = 1'b0;
      limit_reg = LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ECHO_ENABLE: echo_on = cfg_data[0];
          REG_SEMI_ENDS:   semi_on = cfg_data[0];
          REG_LINE_LIMIT:  limit_reg = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result: status %0d tdata 0x%06h last %0d",
                 m_tuser, m_tdata, m_tlast);
          errors++;
        end else begin
          want = owed_q.pop_front();
          check_field("status", want.status, m_tuser);
          check_field("echo_valid", want.echo_valid, m_tdata[TD_ECHO_VALID]);
          check_field("echo_char", want.echo_char, m_tdata[TD_ECHO_LSB +: CHAR_W]);
          check_field("line_valid", want.line_valid, m_tdata[TD_LINE_VALID]);
          check_field("line_char", want.line_char, m_tdata[TD_LINE_LSB +: CHAR_W]);
          check_field("line_length", want.line_length, m_tdata[TD_LEN_LSB +: LEN_W]);
          check_field("tdata_pad", 0, m_tdata[TDATA_W-1:TD_LEN_LSB+LEN_W]);
          check_field("last", want.last, m_tlast);
          n_results++;
          if (want.last && want.status == STATUS_EOL) n_lines++;
          if (want.status == STATUS_OVF) n_drops++;
        end
      end
      if (s_tvalid && s_tready) edit_char(s_tdata);
    end
    pending_cnt  <= owed_q.size();
    fail_count   <= errors;
    results_seen <= n_results;
    lines_seen   <= n_lines;
    drops_seen   <= n_drops;
  end

endmodule

@@ tb/serial_line_editor_core_tb.sv @@
module serial_line_editor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  localparam int LINE_DEPTH   = LINE_DEPTH_DEF;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE       = 4;
  localparam int END_WAIT     = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_ITEMS   = 450;
  localparam int PHASE_ITEMS  = 45;
  localparam int MAX_CYCLES   = 1000000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [TDATA_W-1:0]    m_tdata;
  logic [TUSER_W-1:0]    m_tuser;
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  int fail_count;
  int pending_cnt;
  int results_seen;
  int lines_seen;
  int drops_seen;

  int   chars_sent = 0;
  int   cycle_cnt = 0;
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  logic hold_req = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  serial_line_editor_core #(
    .LINE_DEPTH(LINE_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  serial_line_editor_checker #(
    .LINE_DEPTH(LINE_DEPTH)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending_cnt (pending_cnt),
    .results_seen(results_seen),
    .lines_seen  (lines_seen),
    .drops_seen  (drops_seen)
  );

  // Offer one character after a random gap while gaps are on; return at its transfer edge
  task automatic send_char(input logic [IN_W-1:0] c);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
  endtask

  // Stop offering and wait for every owed result, then let the block settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic echo, input logic semi, input logic [CFG_W-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ECHO_ENABLE;
    cfg_data  <= CFG_W'(echo);
    @(posedge clk);
    cfg_index <= REG_SEMI_ENDS;
    cfg_data  <= CFG_W'(semi);
    @(posedge clk);
    cfg_index <= REG_LINE_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly printable text, some deletes, some raw bytes; top bit random
  function automatic logic [IN_W-1:0] pick_body_char(input logic del_ok);
    int               pick;
    logic [IN_W-1:0]  c;
    pick = $urandom_range(0, 19);
    if (pick < 15 || !del_ok) begin
      c = IN_W'($urandom_range(32, 126));
    end else if (pick < 18) begin
      c[CHAR_W-1:0] = ($urandom_range(0, 1) != 0) ? CH_BS : CH_DEL;
    end else begin
      c = IN_W'($urandom_range(0, 255));
    end
    c[IN_W-1] = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic logic [IN_W-1:0] pick_line_end();
    logic [IN_W-1:0] c;
    case ($urandom_range(0, 3))
      0:       c[CHAR_W-1:0] = CH_NUL;
      1:       c[CHAR_W-1:0] = CH_LF;
      2:       c[CHAR_W-1:0] = CH_CR;
      default: c[CHAR_W-1:0] = CH_SEMI;
    endcase
    c[IN_W-1] = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic send_line(input int max_len, input logic del_ok);
    int len;
    len = $urandom_range(0, max_len);
    for (int i = 0; i < len; i++) send_char(pick_body_char(del_ok));
    send_char(pick_line_end());
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) send_char(IN_W'($urandom_range(0, 255)));
  endtask

  // Result side: random stall per result while stalls are on, one long hold-off on request
  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = rx_idle_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Abort a run that hangs
  initial begin : watchdog
    while (cycle_cnt < MAX_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int ph;
    int lim;
    int lim_eff;
    int phase_end;
    int rand_end;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_ECHO_ENABLE;
    cfg_data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Echo on, semicolon ends line, limit 3: empty delete, storing, top bit,
    // overflow, both delete codes, semicolon end, end on an empty line
    set_config(1'b1, 1'b1, 6'd3);
    send_char(8'h08);
    send_char(8'h41);
    send_char(8'hC2);
    send_char(8'h01);
    send_char(8'h33);
    send_char(8'h7F);
    send_char(8'h88);
    send_char(8'h3B);
    send_char(8'h8D);
    drain_results();

    // Echo off, semicolon stored, limit above depth; NUL and LF ends
    set_config(1'b0, 1'b0, 6'd63);
    send_char(8'h3B);
    send_char(8'hFF);
    send_char(8'h55);
    send_char(8'h8A);
    send_char(8'h80);
    drain_results();

    // Fill to limit 2, then lower the limit to 1 with both characters held
    set_config(1'b1, 1'b0, 6'd2);
    send_char(8'h78);
    send_char(8'h79);
    drain_results();
    set_config(1'b1, 1'b0, 6'd1);
    send_char(8'h7A);
    send_char(8'h08);
    send_char(8'h7B);
    send_char(8'h7F);
    send_char(8'h7C);
    send_char(8'h0D);
    drain_results();

    // Limit zero drops every storable character
    set_config(1'b0, 1'b1, 6'd0);
    send_char(8'h71);
    send_char(8'h0A);
    drain_results();

    // Random phases: mostly lines with random content, some noise bursts
    ph = 0;
    rand_end = chars_sent + RAND_ITEMS;
    while (chars_sent < rand_end) begin
      tx_idle_on = (ph % 3 != 1);
      rx_idle_on = (ph % 3 != 2);
      case (ph % 8)
        0:       lim = 32;
        1:       lim = 63;
        2:       lim = 1;
        3:       lim = 0;
        4:       lim = 2;
        default: lim = $urandom_range(1, 32);
      endcase
      lim_eff = (lim > LINE_DEPTH) ? LINE_DEPTH : lim;
      set_config(1'(ph % 2), 1'((ph / 2) % 2), CFG_W'(lim));
      if (ph == 1) hold_req = 1'b1;
      phase_end = chars_sent + PHASE_ITEMS;
      while (chars_sent < phase_end) begin
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_line(lim_eff + 3, $urandom_range(0, 3) != 0);
      end
      drain_results();
      ph++;
    end

    repeat (END_WAIT) @(posedge clk);
    $display("Sent %0d characters over %0d random phases: %0d results, %0d lines, %0d drops",
             chars_sent, ph, results_seen, lines_seen, drops_seen);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
